// ----- sv/sai_pkg.sv -----
// Shared types and constants for the sorted insertion table.
package sai_pkg;

    // Default table depth
    localparam int CAPACITY_DEF = 16;

    // Fixed field widths
    localparam int DATA_W = 32;
    localparam int IDX_W  = 4;
    localparam int CNT_OUT_W = 5;
    // Number of positions the index field can address
    localparam int IDX_SPAN = 16;

    // Command codes
    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_REVERSE = 2'd1,
        CMD_READ    = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_BADIDX = 2'd3
    } status_t;

    // Per-cycle operation broadcast to every cell
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_TAG,
        CELL_SWAP
    } cell_op_t;

    // Controller states
    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SWAP,
        FSM_DONE
    } fsm_t;

    // Control bundle shared by all cells
    typedef struct packed {
        cell_op_t                  op;
        logic signed [DATA_W-1:0]  value;
        logic [IDX_W-1:0]          index;
        logic                      phase;
    } cell_ctrl_t;

endpackage

// ----- sv/sorted_array_insert_reverse_top.sv -----
// Top level of the sorted insertion table: command controller, cell row and result register.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------
//  input   | in_valid / in_stall  | cmd, value, index
//  output  | out_valid / out_stall| status, read_value, count
//
// Insert, read and unused commands, and reverse of an empty table or of a single entry, are
// answered directly: the result is registered at the transfer edge. Reverse of two or more
// entries first tags the cells, then runs count odd/even swap rounds along the cell row, and
// posts the result once the result register is free.
// Reset clears the fill count, controller state and output valid; entries are not cleared.
// A new command is taken only while the controller is idle and the result register is
// empty or being drained in the same cycle.
module sorted_array_insert_reverse_top #(
    parameter int CAPACITY = sai_pkg::CAPACITY_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           cmd,
    input  logic signed [sai_pkg::DATA_W-1:0]    value,
    input  logic [sai_pkg::IDX_W-1:0]            index,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [1:0]                           status,
    output logic signed [sai_pkg::DATA_W-1:0]    read_value,
    output logic [sai_pkg::CNT_OUT_W-1:0]        count
);
    import sai_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int TAG_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
    localparam logic [CMP_W-1:0] CAP_CMP = CMP_W'(CAPACITY);

    fsm_t                     state_reg;
    fsm_t                     state_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [CNT_W-1:0]         round_reg;
    logic [CNT_W-1:0]         round_next;

    logic                     out_valid_reg;
    status_t                  status_reg;
    logic signed [DATA_W-1:0] read_value_reg;
    logic [CNT_OUT_W-1:0]     count_out_reg;

    logic                     accept;
    logic                     out_free;
    logic                     load_out;
    status_t                  res_status;
    logic signed [DATA_W-1:0] res_read;
    logic                     rd_ok;
    cell_ctrl_t               ctrl;

    logic signed [DATA_W-1:0] ent   [CAPACITY];
    logic [TAG_W-1:0]         tags  [CAPACITY];
    logic                     found [CAPACITY+1];
    logic signed [DATA_W-1:0] rd    [CAPACITY+1];

    // Handshake
    assign in_stall = (state_reg != FSM_IDLE) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Read bounds check
    assign rd_ok = (CMP_W'(index) < CMP_W'(count_reg)) && (CMP_W'(index) < CAP_CMP);

    // Cell row
    assign found[0] = 1'b0;
    assign rd[0]    = '0;

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic signed [DATA_W-1:0] l_entry;
        logic [TAG_W-1:0]         l_tag;
        logic signed [DATA_W-1:0] r_entry;
        logic [TAG_W-1:0]         r_tag;

        if (k == 0)
        begin : g_first
            assign l_entry = '0;
            assign l_tag   = '0;
        end
        else
        begin : g_mid
            assign l_entry = ent[k-1];
            assign l_tag   = tags[k-1];
        end

        if (k == CAPACITY - 1)
        begin : g_last
            assign r_entry = '0;
            assign r_tag   = '0;
        end
        else
        begin : g_inner
            assign r_entry = ent[k+1];
            assign r_tag   = tags[k+1];
        end

        sai_cell #(
            .K     (k),
            .CNT_W (CNT_W),
            .TAG_W (TAG_W)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .count       (count_reg),
            .left_entry  (l_entry),
            .left_tag    (l_tag),
            .right_entry (r_entry),
            .right_tag   (r_tag),
            .found_in    (found[k]),
            .found_out   (found[k+1]),
            .rd_in       (rd[k]),
            .rd_out      (rd[k+1]),
            .entry       (ent[k]),
            .tag         (tags[k])
        );
    end

    // Controller: next state, cell command and result
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        round_next = round_reg;
        ctrl.op    = CELL_HOLD;
        ctrl.value = value;
        ctrl.index = index;
        ctrl.phase = round_reg[0];
        load_out   = 1'b0;
        res_status = STAT_OK;
        res_read   = '0;
        case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    load_out = 1'b1;
                    case (cmd)
                        CMD_INSERT:
                        begin
                            if (count_reg >= CAP_C)
                            begin
                                res_status = STAT_FULL;
                            end
                            else
                            begin
                                ctrl.op    = CELL_INSERT;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_REVERSE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status = STAT_EMPTY;
                            end
                            else if (count_reg != CNT_W'(1))
                            begin
                                // more than one entry: run the swap rounds first
                                load_out   = 1'b0;
                                ctrl.op    = CELL_TAG;
                                round_next = '0;
                                state_next = FSM_SWAP;
                            end
                        end
                        CMD_READ:
                        begin
                            if (rd_ok)
                            begin
                                res_read = rd[CAPACITY];
                            end
                            else
                            begin
                                res_status = STAT_BADIDX;
                            end
                        end
                        default:
                        begin
                            res_status = STAT_OK;
                        end
                    endcase
                end
            end
            FSM_SWAP:
            begin
                ctrl.op    = CELL_SWAP;
                round_next = round_reg + 1'b1;
                if (round_reg == (count_reg - 1'b1))
                begin
                    state_next = FSM_DONE;
                end
            end
            FSM_DONE:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            count_reg     <= '0;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            round_reg <= round_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status_reg     <= res_status;
            read_value_reg <= res_read;
            count_out_reg  <= CNT_OUT_W'(count_next);
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign read_value = read_value_reg;
    assign count      = count_out_reg;

endmodule

// ----- sv/sai_cell.sv -----
// One storage cell of the table: holds an entry and a reorder tag, trades with neighbors.
module sai_cell #(
    parameter int K     = 0,
    parameter int CNT_W = $clog2(sai_pkg::CAPACITY_DEF + 1),
    parameter int TAG_W = $clog2(sai_pkg::CAPACITY_DEF)
) (
    input  logic                              clk,
    input  sai_pkg::cell_ctrl_t               ctrl,
    input  logic [CNT_W-1:0]                  count,
    input  logic signed [sai_pkg::DATA_W-1:0] left_entry,
    input  logic [TAG_W-1:0]                  left_tag,
    input  logic signed [sai_pkg::DATA_W-1:0] right_entry,
    input  logic [TAG_W-1:0]                  right_tag,
    input  logic                              found_in,
    output logic                              found_out,
    input  logic signed [sai_pkg::DATA_W-1:0] rd_in,
    output logic signed [sai_pkg::DATA_W-1:0] rd_out,
    output logic signed [sai_pkg::DATA_W-1:0] entry,
    output logic [TAG_W-1:0]                  tag
);
    import sai_pkg::*;

    // Position constants of this cell
    localparam logic [CNT_W-1:0] POS_C   = CNT_W'(K);
    localparam logic [CNT_W-1:0] NEXT_C  = CNT_W'(K + 1);
    localparam logic [TAG_W-1:0] POS_T   = TAG_W'(K);
    localparam logic [IDX_W-1:0] POS_I   = IDX_W'(K % IDX_SPAN);
    localparam bit               ADDR_OK = (K < IDX_SPAN);
    localparam bit               HAS_LEFT = (K > 0);
    localparam bit               POS_ODD = ((K % 2) == 1);

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    logic [TAG_W-1:0]         tag_reg;
    logic [TAG_W-1:0]         tag_next;

    logic valid;
    logic at_end;
    logic right_ok;
    logic ge;
    logic lower;
    logic upper;

    // Occupancy and compare against the broadcast value
    assign valid    = (POS_C < count);
    assign at_end   = (POS_C == count);
    assign right_ok = (NEXT_C < count);
    assign ge       = (entry_reg >= ctrl.value);

    // First-greater-or-equal search ripples toward higher positions
    assign found_out = found_in | (valid & ge);

    // Pair role in the current odd/even round
    assign lower = (POS_ODD == ctrl.phase);
    assign upper = (POS_ODD != ctrl.phase) && HAS_LEFT;

    // Read path: matching cell replaces the passing value
    assign rd_out = (ADDR_OK && (ctrl.index == POS_I)) ? entry_reg : rd_in;

    // Next entry and tag
    always_comb
    begin
        entry_next = entry_reg;
        tag_next   = tag_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (valid || at_end)
                begin
                    if (found_in)
                    begin
                        entry_next = left_entry;
                    end
                    else if ((valid && ge) || at_end)
                    begin
                        entry_next = ctrl.value;
                    end
                end
            end
            CELL_TAG:
            begin
                tag_next = POS_T;
            end
            CELL_SWAP:
            begin
                if (lower && right_ok && (tag_reg < right_tag))
                begin
                    entry_next = right_entry;
                    tag_next   = right_tag;
                end
                else if (upper && valid && (left_tag < tag_reg))
                begin
                    entry_next = left_entry;
                    tag_next   = left_tag;
                end
            end
            default:
            begin
                entry_next = entry_reg;
                tag_next   = tag_reg;
            end
        endcase
    end

    // Storage
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        tag_reg   <= tag_next;
    end

    assign entry = entry_reg;
    assign tag   = tag_reg;

endmodule

// ----- test/sorted_array_insert_reverse_top_test.sv -----
// Testbench for the sorted insertion table: directed and random commands against a behavioral table.
`timescale 1ns / 1ps

module sorted_array_insert_reverse_top_test;
    import sai_pkg::*;

    localparam int CAP          = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 480;
    localparam int HOLD_CYCLES  = 60;
    localparam int QUIET_LIMIT  = 2000;
    // room for a reverse of a full table to finish
    localparam int TAIL_CYCLES  = CAP + 8;

    typedef struct {
        status_t                   status;
        logic signed [DATA_W-1:0]  read_value;
        logic [CNT_OUT_W-1:0]      count;
    } table_result_t;

    // Tracks the table contents and the results still owed by the block
    class sorted_table_tracker;
        logic signed [DATA_W-1:0] slots [CAP];
        int            fill;
        table_result_t pending_results [$];
        int            errors;
        int            checked;
        int            n_insert, n_full, n_reverse, n_empty, n_read, n_badidx, n_unused;

        function new();
            foreach (slots[k])
                slots[k] = '0;
            fill      = 0;
            errors    = 0;
            checked   = 0;
            n_insert  = 0;
            n_full    = 0;
            n_reverse = 0;
            n_empty   = 0;
            n_read    = 0;
            n_badidx  = 0;
            n_unused  = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Apply one accepted command to the table and queue its result
        function void note_command(cmd_t op, logic signed [DATA_W-1:0] val,
                                   logic [IDX_W-1:0] idx);
            table_result_t r;
            logic signed [DATA_W-1:0] tmp;
            int pos;
            int k;
            int lo;
            int hi;
            r.status     = STAT_OK;
            r.read_value = '0;
            case (op)
                CMD_INSERT:
                begin
                    n_insert++;
                    if (fill >= CAP)
                    begin
                        r.status = STAT_FULL;
                        n_full++;
                    end
                    else
                    begin
                        // goes before the first entry that is greater or equal
                        pos = fill;
                        for (k = 0; k < fill; k++)
                            if (slots[k] >= val)
                            begin
                                pos = k;
                                break;
                            end
                        for (k = fill; k > pos; k--)
                            slots[k] = slots[k-1];
                        slots[pos] = val;
                        fill++;
                    end
                end
                CMD_REVERSE:
                begin
                    n_reverse++;
                    if (fill == 0)
                    begin
                        r.status = STAT_EMPTY;
                        n_empty++;
                    end
                    else
                    begin
                        lo = 0;
                        hi = fill - 1;
                        while (lo < hi)
                        begin
                            tmp       = slots[lo];
                            slots[lo] = slots[hi];
                            slots[hi] = tmp;
                            lo++;
                            hi--;
                        end
                    end
                end
                CMD_READ:
                begin
                    n_read++;
                    if (int'(idx) < fill)
                        r.read_value = slots[idx];
                    else
                    begin
                        r.status = STAT_BADIDX;
                        n_badidx++;
                    end
                end
                default:
                    n_unused++;
            endcase
            r.count = CNT_OUT_W'(fill);
            pending_results.push_back(r);
        endfunction

        // Compare one result transfer with the oldest expectation
        function void check_result(logic [1:0] st, logic signed [DATA_W-1:0] rv,
                                   logic [CNT_OUT_W-1:0] cnt);
            table_result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no command pending: status %0d value %0d count %0d",
                       st, rv, cnt);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (st !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, st);
                errors++;
            end
            if (rv !== want.read_value)
            begin
                $error("read_value: expected %0d, actual %0d", want.read_value, rv);
                errors++;
            end
            if (cnt !== want.count)
            begin
                $error("count: expected %0d, actual %0d", want.count, cnt);
                errors++;
            end
        endfunction

        function void report_leftovers();
            if (pending_results.size() != 0)
            begin
                $error("%0d results never arrived", pending_results.size());
                errors++;
            end
        endfunction
    endclass

    logic                       clk        = 1'b0;
    logic                       rst_n      = 1'b0;
    logic                       in_valid   = 1'b0;
    logic                       in_stall;
    logic [1:0]                 cmd        = CMD_NOP;
    logic signed [DATA_W-1:0]   value      = '0;
    logic [IDX_W-1:0]           index      = '0;
    logic                       out_valid;
    logic                       out_stall  = 1'b0;
    logic [1:0]                 status;
    logic signed [DATA_W-1:0]   read_value;
    logic [CNT_OUT_W-1:0]       count;

    sorted_table_tracker table_track;
    bit  gaps_on  = 1'b1;
    bit  hold_req = 1'b0;
    int  quiet_cycles = 0;

    sorted_array_insert_reverse_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .value      (value),
        .index      (index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .read_value (read_value),
        .count      (count)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Offer one command, optionally after a random gap, and wait for its transfer
    task automatic send_cmd(input cmd_t op, input logic signed [DATA_W-1:0] val,
                            input logic [IDX_W-1:0] idx);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        value    <= val;
        index    <= idx;
        do
            @(posedge clk);
        while (in_stall);
        table_track.note_command(op, val, idx);
    endtask

    // Random command; values lean toward duplicates and extremes
    task automatic send_random_item();
        cmd_t op;
        logic signed [DATA_W-1:0] val;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            op = CMD_INSERT;
        else if (pick < 50)
            op = CMD_REVERSE;
        else if (pick < 92)
            op = CMD_READ;
        else
            op = CMD_NOP;
        pick = $urandom_range(0, 7);
        if (pick < 2)
            val = DATA_W'($urandom_range(0, 6)) - 32'sd3;
        else if (pick == 2)
            val = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        else
            val = $urandom;
        send_cmd(op, val, IDX_W'($urandom_range(0, IDX_SPAN - 1)));
    endtask

    // Pause the sender until every owed result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (table_track.pending() != 0);
    endtask

    // Result side: random stall bursts, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            table_track.check_result(status, read_value, count);
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAIL sorted_array_insert_reverse_top");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin
        table_track = new;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty table cases and the unused code
        send_cmd(CMD_READ, 32'sd0, 4'd0);
        send_cmd(CMD_REVERSE, 32'sd0, 4'd0);
        send_cmd(CMD_NOP, 32'sh5a5a5a5a, 4'd9);
        send_cmd(CMD_READ, 32'sd0, 4'd15);
        // extremes and equal values
        send_cmd(CMD_INSERT, 32'sh7fffffff, 4'd0);
        send_cmd(CMD_INSERT, 32'sh80000000, 4'd0);
        send_cmd(CMD_INSERT, 32'sd0, 4'd0);
        send_cmd(CMD_INSERT, -32'sd1, 4'd0);
        send_cmd(CMD_INSERT, 32'sd0, 4'd0);
        send_cmd(CMD_INSERT, 32'sh80000000, 4'd0);
        send_cmd(CMD_INSERT, 32'sh7fffffff, 4'd0);
        send_cmd(CMD_READ, 32'sd0, 4'd0);
        send_cmd(CMD_READ, 32'sd0, 4'd6);
        send_cmd(CMD_READ, 32'sd0, 4'd7);
        // reverse, then insert into a descending table
        send_cmd(CMD_REVERSE, 32'sd0, 4'd0);
        send_cmd(CMD_READ, 32'sd0, 4'd0);
        send_cmd(CMD_READ, 32'sd0, 4'd6);
        send_cmd(CMD_INSERT, 32'sd5, 4'd0);
        send_cmd(CMD_REVERSE, 32'sd0, 4'd0);
        send_cmd(CMD_READ, 32'sd0, 4'd3);
        drain_results();

        // random part; a quiet window holds the long receiver hold-off
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            gaps_on = !((n >= 170 && n < 230) || n >= 400);
            if (n == 175)
                hold_req = 1'b1;
            if (n == 300)
                drain_results();
            send_random_item();
        end

        // wind down
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        table_track.report_leftovers();
        $display("Ran %0d inserts (%0d on a full table), %0d reverses (%0d on an empty table),",
                 table_track.n_insert, table_track.n_full, table_track.n_reverse,
                 table_track.n_empty);
        $display("%0d reads (%0d out of range), %0d unused codes; %0d results checked, %0d errors",
                 table_track.n_read, table_track.n_badidx, table_track.n_unused,
                 table_track.checked, table_track.errors);
        if (table_track.errors == 0)
            $display("PASS sorted_array_insert_reverse_top");
        else
            $display("FAIL sorted_array_insert_reverse_top");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/sai_pkg.sv
sv/sai_cell.sv
sv/sorted_array_insert_reverse_top.sv
test/sorted_array_insert_reverse_top_test.sv
